/* hw/rtl/kesd_pkg.sv */
package kesd_pkg;

    // Number of configured key sequences: left, right, up, down, delete, backspace
    localparam int NUM_KEYS = 6;
    localparam int BYTE_W   = 8;
    localparam int SEQ_W    = 64;
    localparam int KEY_W    = 3;

    // Key codes, in priority order
    localparam logic [KEY_W-1:0] KEY_LEFT      = 3'd0;
    localparam logic [KEY_W-1:0] KEY_RIGHT     = 3'd1;
    localparam logic [KEY_W-1:0] KEY_UP        = 3'd2;
    localparam logic [KEY_W-1:0] KEY_DOWN      = 3'd3;
    localparam logic [KEY_W-1:0] KEY_DELETE    = 3'd4;
    localparam logic [KEY_W-1:0] KEY_BACKSPACE = 3'd5;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [SEQ_W-1:0]  seq_t;
    typedef logic [KEY_W-1:0]  key_t;

    // Verdict of the compare unit for one key against the pending bytes
    typedef struct packed {
        logic full;    // pending bytes equal the whole sequence
        logic prefix;  // pending bytes are a proper prefix of the sequence
    } kesd_match_t;

endpackage

/* hw/rtl/kesd_cfg_regs.sv */
module kesd_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  kesd_pkg::key_t cfg_addr,
    input  kesd_pkg::seq_t cfg_wr_data,
    input  kesd_pkg::key_t rd_key,
    output kesd_pkg::seq_t rd_seq
);
    import kesd_pkg::*;

    seq_t seq_reg [NUM_KEYS];

    // Sequence registers; writes beyond the last key are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                seq_reg[i] <= '0;
            end
        end else if (cfg_wr_en && (cfg_addr < key_t'(NUM_KEYS))) begin
            seq_reg[cfg_addr] <= cfg_wr_data;
        end
    end

    // Read port for the key under test
    assign rd_seq = (rd_key < key_t'(NUM_KEYS)) ? seq_reg[rd_key] : '0;

endmodule

/* hw/rtl/kesd_match_unit.sv */
module kesd_match_unit #(
    parameter int MAX_SEQ_LEN = 8,
    parameter int CNT_W       = $clog2(MAX_SEQ_LEN + 1)
) (
    input  kesd_pkg::seq_t      seq,
    input  kesd_pkg::byte_t     pend_bytes [MAX_SEQ_LEN],
    input  logic [CNT_W-1:0]    pend_count,
    output kesd_pkg::kesd_match_t result
);
    import kesd_pkg::*;

    logic [CNT_W-1:0] seq_len;
    logic             len_done;
    logic             head_ok;

    // Sequence length: bytes before the first zero byte
    always_comb begin
        seq_len  = '0;
        len_done = 1'b0;
        for (int i = 0; i < MAX_SEQ_LEN; i++) begin
            if (!len_done && (seq[BYTE_W*i +: BYTE_W] != '0)) begin
                seq_len = CNT_W'(i + 1);
            end else begin
                len_done = 1'b1;
            end
        end
    end

    // Head compare over the pending bytes, all positions in parallel
    always_comb begin
        head_ok = 1'b1;
        for (int i = 0; i < MAX_SEQ_LEN; i++) begin
            if ((CNT_W'(i) < pend_count) && (pend_bytes[i] != seq[BYTE_W*i +: BYTE_W])) begin
                head_ok = 1'b0;
            end
        end
    end

    assign result.full   = head_ok && (seq_len != '0) && (seq_len == pend_count);
    assign result.prefix = head_ok && (seq_len > pend_count);

endmodule

/* hw/rtl/key_escape_sequence_decoder.sv */
// Key escape sequence decoder. Each byte from the terminal is appended to a
// pending buffer of up to MAX_SEQ_LEN bytes (a further byte overwrites the
// newest). The pending bytes are then tested against the six configured key
// sequences (left, right, up, down, delete, backspace; an all-zero register
// disables its key) by one shared compare unit, one key per cycle while the
// output is not stalled. A full match emits the key code with tuser set; a
// prefix of some sequence waits for more bytes; otherwise the oldest pending
// byte goes out as a plain byte and the rest is rescanned. The last result
// caused by an input byte carries tlast; a byte that only extends a prefix
// produces no result. One input byte is accepted, scanned in up to
// MAX_SEQ_LEN passes over the six keys and then flushed; the sequence
// registers are read through a single port into the compare unit, and
// s_tready is high only while the decoder is idle.
// Configuration is written with cfg_wr_en / cfg_addr / cfg_wr_data while idle.
module key_escape_sequence_decoder #(
    parameter int MAX_SEQ_LEN = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input byte stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] in_byte
    // decoded stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,    // [7:0] value
    output logic [0:0]            m_tuser,    // [0] is_key
    output logic                  m_tlast,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  kesd_pkg::key_t        cfg_addr,
    input  kesd_pkg::seq_t        cfg_wr_data
);
    import kesd_pkg::*;

    localparam int CNT_W = $clog2(MAX_SEQ_LEN + 1);
    localparam int IDX_W = $clog2(MAX_SEQ_LEN);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]       state_reg,    state_next;
    key_t             key_reg,      key_next;
    logic             prefix_reg,   prefix_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    byte_t            pend_reg [MAX_SEQ_LEN];

    logic             held_vld_reg, held_vld_next;
    logic             held_key_reg, held_key_next;
    byte_t            held_val_reg, held_val_next;

    logic             out_vld_reg,  out_vld_next;
    logic             out_key_reg,  out_key_next;
    byte_t            out_val_reg,  out_val_next;
    logic             out_last_reg, out_last_next;

    logic             in_req;
    logic             out_free;
    logic             do_append;
    logic             do_shift;
    logic [IDX_W-1:0] wr_idx;
    seq_t             cur_seq;
    kesd_match_t      match;
    logic             new_res;
    logic             new_key;
    byte_t            new_val;
    logic             prefix_acc;

    kesd_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .rd_key      (key_reg),
        .rd_seq      (cur_seq)
    );

    kesd_match_unit #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN),
        .CNT_W       (CNT_W)
    ) u_match (
        .seq        (cur_seq),
        .pend_bytes (pend_reg),
        .pend_count (count_reg),
        .result     (match)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_req   = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_val_reg;
    assign m_tuser[0] = out_key_reg;
    assign m_tlast    = out_last_reg;

    // Full buffer: the newest byte is overwritten
    assign wr_idx = (count_reg >= CNT_W'(MAX_SEQ_LEN)) ? IDX_W'(MAX_SEQ_LEN - 1)
                                                        : count_reg[IDX_W-1:0];

    assign prefix_acc = prefix_reg || match.prefix;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        key_next      = key_reg;
        prefix_next   = prefix_reg;
        count_next    = count_reg;
        held_vld_next = held_vld_reg;
        held_key_next = held_key_reg;
        held_val_next = held_val_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_key_next  = out_key_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;
        do_append     = 1'b0;
        do_shift      = 1'b0;
        new_res       = 1'b0;
        new_key       = 1'b0;
        new_val       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_req) begin
                    do_append   = 1'b1;
                    count_next  = (count_reg >= CNT_W'(MAX_SEQ_LEN)) ? CNT_W'(MAX_SEQ_LEN)
                                                                      : count_reg + 1'b1;
                    key_next    = KEY_LEFT;
                    prefix_next = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    if (match.full) begin
                        new_res    = 1'b1;
                        new_key    = 1'b1;
                        new_val    = BYTE_W'(key_reg);
                        count_next = '0;
                        state_next = ST_FLUSH;
                    end else if (key_reg != KEY_BACKSPACE) begin
                        key_next    = key_reg + 1'b1;
                        prefix_next = prefix_acc;
                    end else if (prefix_acc) begin
                        state_next = ST_FLUSH;
                    end else begin
                        // no key can follow: oldest byte leaves as plain data
                        new_res     = 1'b1;
                        new_key     = 1'b0;
                        new_val     = pend_reg[0];
                        do_shift    = 1'b1;
                        count_next  = count_reg - 1'b1;
                        key_next    = KEY_LEFT;
                        prefix_next = 1'b0;
                        state_next  = (count_reg == CNT_W'(1)) ? ST_FLUSH : ST_SCAN;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    if (held_vld_reg) begin
                        out_vld_next  = 1'b1;
                        out_key_next  = held_key_reg;
                        out_val_next  = held_val_reg;
                        out_last_next = 1'b1;
                        held_vld_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A new result pushes the held one out; last is known only at the end
        if (new_res) begin
            if (held_vld_reg) begin
                out_vld_next  = 1'b1;
                out_key_next  = held_key_reg;
                out_val_next  = held_val_reg;
                out_last_next = 1'b0;
            end
            held_vld_next = 1'b1;
            held_key_next = new_key;
            held_val_next = new_val;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            key_reg      <= KEY_LEFT;
            prefix_reg   <= 1'b0;
            count_reg    <= '0;
            held_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            key_reg      <= key_next;
            prefix_reg   <= prefix_next;
            count_reg    <= count_next;
            held_vld_reg <= held_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        held_key_reg <= held_key_next;
        held_val_reg <= held_val_next;
        out_key_reg  <= out_key_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
    end

    // Pending byte buffer: append at the tail, shift out at the head
    always_ff @(posedge aclk) begin
        if (do_append) begin
            pend_reg[wr_idx] <= s_tdata;
        end else if (do_shift) begin
            for (int i = 0; i < MAX_SEQ_LEN - 1; i++) begin
                pend_reg[i] <= pend_reg[i+1];
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_SEQ_LEN))
        else $error("pending count above buffer depth");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (count_reg != '0))
        else $error("scan with no pending bytes");

    a_idle_no_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !held_vld_reg)
        else $error("held result left behind in idle");

    a_key_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (key_reg < key_t'(NUM_KEYS)))
        else $error("key index out of range");

    a_full_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && out_free && match.full) |=>
            (state_reg == ST_FLUSH && count_reg == '0 && held_vld_reg && held_key_reg))
        else $error("full match did not end the scan");
`endif

endmodule
